// ===== rtl/brs_pkg.sv =====
// Package for the 1-bpp row shear block: payload and command types, register
// indices and shared constants. Depends on nothing; every other file imports it.
package brs_pkg;

    // Widths fixed by the field and register definitions.
    localparam int ROW_LEN_W  = 11;
    localparam int STEP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SHIFT_W    = 3;
    localparam int LEAD_W     = 6;

    // Position fields of a command; wide enough for rows of up to 16384 bytes.
    localparam int CMD_POS_W = 14;

    // Defaults for the top-level parameters.
    localparam int MAX_ROW_BYTES_DEF = 1024;
    localparam int CMD_QUEUE_DEPTH   = 4;

    // Offset saturation point.
    localparam logic [LEAD_W-1:0]  LEAD_MAX  = 6'd62;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd7;

    localparam logic [7:0] WHITE_BYTE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OLD_ROW_BYTES = 2'd0,
        REG_NEW_ROW_BYTES = 2'd1,
        REG_ROWS_PER_STEP = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_image;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_row;
    } t_out_item;

    // One run of output positions: pos_first to pos_last inclusive, all white
    // except an optional data byte at pos_mid.
    typedef struct packed {
        logic [CMD_POS_W-1:0] pos_first;
        logic [CMD_POS_W-1:0] pos_mid;
        logic [CMD_POS_W-1:0] pos_last;
        logic [7:0]           mid_val;
        logic                 has_mid;
        logic                 eor;
    } t_cmd;

endpackage

// ===== rtl/brs_front.sv =====
// Front end of the row shear: configuration registers, shear state and the
// classification of each source byte into one output run. Depends on brs_pkg.
module brs_front import brs_pkg::*; #(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_in_item              i_in,
    input  logic                  i_q_full,
    output logic                  o_full,
    output logic                  o_cmd_push,
    output t_cmd                  o_cmd
);

    localparam int CW  = $clog2(MAX_ROW_BYTES);
    localparam int AW0 = $clog2(MAX_ROW_BYTES + 64) + 1;
    localparam int AW  = (AW0 > 12) ? AW0 : 12;

    localparam logic [AW-1:0] ONE_A  = AW'(1);
    localparam logic [AW-1:0] TWO_A  = AW'(2);
    localparam logic [AW-1:0] MAX_A  = AW'(MAX_ROW_BYTES);
    localparam logic [AW-1:0] LEAD_A = AW'(LEAD_MAX);

    logic [ROW_LEN_W-1:0] r_old_row_bytes, r_new_row_bytes;
    logic [STEP_W-1:0]    r_rows_per_step;

    logic [SHIFT_W-1:0] r_bit_shift, n_bit_shift;
    logic [LEAD_W-1:0]  r_lead_bytes, n_lead_bytes;
    logic [STEP_W-1:0]  r_rows_in_step, n_rows_in_step;
    logic               r_first_step_done, n_first_step_done;
    logic [CW-1:0]      r_column, n_column;
    logic [7:0]         r_held_bits, n_held_bits;

    logic               accept, sof;
    logic [SHIFT_W-1:0] shift_eff;
    logic [LEAD_W-1:0]  lead_eff;
    logic [STEP_W-1:0]  rows_eff;
    logic               first_eff;
    logic [CW-1:0]      col_eff;
    logic [7:0]         held0, held_eff;
    logic [15:0]        byte_sh;

    logic [AW-1:0] old_a, new_a, ob, nb_c, nb_lim, nb, lead_a, c_a, lead_fit;
    logic [AW-1:0] mid_full, mid_cap, mid_pos, run_first, run_last;
    logic          is_first, is_last, data_ok, mid_emit, run_valid, run_mid;
    logic [7:0]    run_val;

    logic [STEP_W-1:0] target, target1, rows_inc;
    logic              step_hit;

    assign accept = i_push && !i_q_full;
    assign o_full = i_q_full;

    always_comb begin
        sof       = i_in.start_of_image;
        shift_eff = sof ? '0 : r_bit_shift;
        lead_eff  = sof ? '0 : r_lead_bytes;
        rows_eff  = sof ? '0 : r_rows_in_step;
        first_eff = sof ? 1'b0 : r_first_step_done;
        col_eff   = sof ? '0 : r_column;
        is_first  = (col_eff == '0);

        held0    = ~(WHITE_BYTE >> shift_eff);
        held_eff = is_first ? held0 : r_held_bits;
        byte_sh  = {i_in.in_byte, 8'h00} >> shift_eff;

        // Row lengths clamped to the legal range.
        old_a  = AW'(r_old_row_bytes);
        new_a  = AW'(r_new_row_bytes);
        ob     = (old_a == '0) ? ONE_A : ((old_a > MAX_A) ? MAX_A : old_a);
        nb_c   = (new_a == '0) ? ONE_A : ((new_a > MAX_A) ? MAX_A : new_a);
        nb_lim = ob + LEAD_A;
        nb     = (nb_c > nb_lim) ? nb_lim : nb_c;

        lead_a   = AW'(lead_eff);
        c_a      = AW'(col_eff);
        is_last  = (c_a + ONE_A) >= ob;
        data_ok  = (lead_a + c_a + TWO_A) < nb;
        lead_fit = (lead_a < nb) ? lead_a : nb;

        // Position of the closing byte of a row.
        mid_full = lead_a + ob - ONE_A;
        mid_cap  = nb - TWO_A;
        if (nb >= lead_a + TWO_A) begin
            mid_pos = (mid_full < mid_cap) ? mid_full : mid_cap;
        end else begin
            mid_pos = lead_a;
        end
        mid_emit = mid_pos < nb;

        if (!is_last) begin
            run_val = held_eff | byte_sh[15:8];
            if (is_first) begin
                run_first = '0;
                run_mid   = data_ok;
                run_valid = data_ok || (lead_fit != '0);
                run_last  = data_ok ? lead_a : (lead_fit - ONE_A);
            end else begin
                run_first = lead_a + c_a;
                run_mid   = 1'b1;
                run_valid = data_ok;
                run_last  = lead_a + c_a;
            end
        end else begin
            run_val   = held_eff | (WHITE_BYTE >> shift_eff);
            run_first = is_first ? '0 : mid_pos;
            run_mid   = mid_emit;
            run_valid = is_first || mid_emit;
            run_last  = nb - ONE_A;
        end

        o_cmd.pos_first = CMD_POS_W'(run_first);
        o_cmd.pos_mid   = CMD_POS_W'(is_last ? mid_pos : run_last);
        o_cmd.pos_last  = CMD_POS_W'(run_last);
        o_cmd.mid_val   = run_val;
        o_cmd.has_mid   = run_mid;
        o_cmd.eor       = (run_last == nb - ONE_A);
        o_cmd_push      = accept && run_valid;

        // End-of-row step bookkeeping.
        target   = first_eff ? r_rows_per_step : (r_rows_per_step >> 1);
        target1  = (target == '0) ? STEP_W'(1) : target;
        rows_inc = rows_eff + STEP_W'(1);
        step_hit = rows_inc >= target1;

        n_bit_shift       = shift_eff;
        n_lead_bytes      = lead_eff;
        n_rows_in_step    = rows_eff;
        n_first_step_done = first_eff;
        if (is_last) begin
            n_column = '0;
            if (step_hit) begin
                n_rows_in_step    = '0;
                n_first_step_done = 1'b1;
                if (shift_eff < SHIFT_MAX) begin
                    n_bit_shift = shift_eff + SHIFT_W'(1);
                end else if (lead_eff < LEAD_MAX) begin
                    n_bit_shift  = '0;
                    n_lead_bytes = lead_eff + LEAD_W'(1);
                end
            end else begin
                n_rows_in_step = rows_inc;
            end
        end else begin
            n_column = col_eff + CW'(1);
        end

        if (!is_last && data_ok) begin
            n_held_bits = byte_sh[7:0];
        end else begin
            n_held_bits = held_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_row_bytes   <= ROW_LEN_W'(1);
            r_new_row_bytes   <= ROW_LEN_W'(1);
            r_rows_per_step   <= STEP_W'(2);
            r_bit_shift       <= '0;
            r_lead_bytes      <= '0;
            r_rows_in_step    <= '0;
            r_first_step_done <= 1'b0;
            r_column          <= '0;
            r_held_bits       <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_OLD_ROW_BYTES: r_old_row_bytes <= i_cfg_data[ROW_LEN_W-1:0];
                    REG_NEW_ROW_BYTES: r_new_row_bytes <= i_cfg_data[ROW_LEN_W-1:0];
                    REG_ROWS_PER_STEP: r_rows_per_step <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_bit_shift       <= n_bit_shift;
                r_lead_bytes      <= n_lead_bytes;
                r_rows_in_step    <= n_rows_in_step;
                r_first_step_done <= n_first_step_done;
                r_column          <= n_column;
                r_held_bits       <= n_held_bits;
            end
        end
    end

    // A run handed on is never empty.
    a_run_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> (o_cmd.pos_first <= o_cmd.pos_last))
        else $error("front produced an empty run");

    // A data byte always lies inside its run.
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd.has_mid) |->
            (o_cmd.pos_mid >= o_cmd.pos_first && o_cmd.pos_mid <= o_cmd.pos_last))
        else $error("data byte outside its run");

endmodule

// ===== rtl/brs_cmd_fifo.sv =====
// Short command queue between the front and back ends of the row shear,
// held in flip-flops. Depends on brs_pkg for the command type.
module brs_cmd_fifo import brs_pkg::*; #(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_count;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + NW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("command queue underflow");

endmodule

// ===== rtl/brs_back.sv =====
// Back end of the row shear: expands each queued run into output bytes in a
// result register, one a cycle while it is free or read. Depends on brs_pkg.
module brs_back import brs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_cmd      i_q_data,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    logic                 r_act;
    t_cmd                 r_cmd;
    logic [CMD_POS_W-1:0] r_pos;
    logic                 r_ovalid;
    t_out_item            r_out;

    logic      out_free, step, cur_last, need;
    t_out_item cur_item;

    always_comb begin
        out_free = !r_ovalid || i_pop;
        step     = r_act && out_free;
        cur_last = (r_pos == r_cmd.pos_last);
        need     = !r_act || (step && cur_last);
        o_q_pop  = need && !i_q_empty;

        cur_item.out_byte   = (r_cmd.has_mid && r_pos == r_cmd.pos_mid) ?
                              r_cmd.mid_val : WHITE_BYTE;
        cur_item.end_of_row = r_cmd.eor && cur_last;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_data;
        end
        if (step) begin
            r_out <= cur_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_act <= 1'b1;
                r_pos <= i_q_data.pos_first;
            end else if (step && cur_last) begin
                r_act <= 1'b0;
            end else if (step) begin
                r_pos <= r_pos + CMD_POS_W'(1);
            end
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_ovalid;
    assign o_out   = r_out;

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_pos >= r_cmd.pos_first && r_pos <= r_cmd.pos_last))
        else $error("back end walked past its run");

endmodule

// ===== rtl/bitmap_row_shear_1bpp.sv =====
// Top level of the 1-bpp horizontal row shear. Holds the front end, the
// command queue and the back end; depends on brs_pkg and those three modules.
//
// Use: source bytes of a 1-bpp bitmap (msb leftmost, 1 is white) are written
// through a queue-like input: a transfer happens at a clock edge where push is
// high and full is low. start_of_image on the first byte of an image clears
// the shear offset, the lead count and the row counters before that byte is
// used. Sheared output bytes are read through a queue-like output: while
// empty is low the oldest result is on o_out, and a transfer happens at an
// edge where pop is high. end_of_row marks the last byte of each output row.
// Row lengths and the step length are set through the configuration channel,
// whose ready is always high; the user is to write registers only while the
// block is idle, which the block does not enforce. Each source byte makes
// between zero and about 64 output bytes, mostly one. The front end
// classifies one input byte per cycle and the back end produces one output
// byte per cycle when neither is stalled, so the sustained rate is one byte
// per cycle on both sides; the bursts of white fill at the start and end of
// a row stall the input once the command queue (QUEUE_DEPTH runs) fills up.
// A stalled receiver simply holds the result register and, through the queue,
// eventually the input. Synchronous reset empties the queue and the result
// register and restores the register defaults (row lengths 1, step 2).
module bitmap_row_shear_1bpp import brs_pkg::*; #(
    parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
    parameter int QUEUE_DEPTH   = CMD_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic q_full, q_empty, q_push, q_pop;
    t_cmd q_in, q_out;

    // Register writes are always taken at once.
    assign o_cfg_ready = 1'b1;

    // The front end turns every accepted byte into at most one run of
    // output positions, which waits in the queue until the back end is free.
    brs_front #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_cmd_push  (q_push),
        .o_cmd       (q_in)
    );

    brs_cmd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // The back end walks each run one position a cycle into the result
    // register, which a held pop leaves untouched.
    brs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

    // Checks that the last byte of every output row is pure white fill.
    a_row_ends_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.end_of_row) |-> (o_out.out_byte == WHITE_BYTE))
        else $error("row closed on a byte that is not white");

    // Nothing is offered straight after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> empty)
        else $error("result offered straight after reset");

endmodule
